// ----- rtl/core/psi_pkg.sv -----
package psi_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned Q_W           = 17;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned MAX_ITEMS_DEF = 64;

  localparam logic [Q_W-1:0] Q_ONE   = Q_W'(65536);
  localparam logic [Q_W-1:0] Q_RESET = Q_W'(32768);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SHIFT,
    ST_PROD,
    ST_OUT
  } psi_state_e;

  // Commands that go to every cell of the chain at once.
  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_ctl_t;

endpackage

// ----- rtl/core/psi_cell.sv -----
module psi_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  psi_pkg::cell_ctl_t                  ctl_i,
  input  logic signed [psi_pkg::DATA_W-1:0]   sample_i,
  input  logic signed [psi_pkg::DATA_W-1:0]   prev_val_i,
  input  logic                                prev_occ_i,
  input  logic                                prev_gt_i,
  input  logic signed [psi_pkg::DATA_W-1:0]   next_val_i,
  input  logic                                next_occ_i,
  output logic signed [psi_pkg::DATA_W-1:0]   val_o,
  output logic                                occ_o,
  output logic                                gt_o
);
  import psi_pkg::*;

  logic signed [DATA_W-1:0] val_q;
  logic                     occ_q;

  assign gt_o  = occ_q && (val_q > sample_i);
  assign val_o = val_q;
  assign occ_o = occ_q;

  // Insertion: a cell whose left neighbor holds a larger value takes that value;
  // the first cell holding a larger value, or the first free cell, takes the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (ctl_i.clr) begin
      occ_q <= 1'b0;
    end else if (ctl_i.shift) begin
      occ_q <= next_occ_i;
    end else if (ctl_i.ins) begin
      occ_q <= prev_occ_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      val_q <= next_val_i;
    end else if (ctl_i.ins) begin
      if (prev_gt_i) begin
        val_q <= prev_val_i;
      end else if (gt_o || (prev_occ_i && !occ_q)) begin
        val_q <= sample_i;
      end
    end
  end

endmodule

// ----- rtl/core/psi_seq.sv -----
module psi_seq #(
  parameter int unsigned MaxItems = psi_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               has_value_i,
  input  logic                               last_item_i,
  input  logic                               cfg_we_i,
  input  logic [psi_pkg::Q_W-1:0]            quantile_fraction_i,
  input  logic signed [psi_pkg::DATA_W-1:0]  head_val_i,
  input  logic signed [psi_pkg::DATA_W-1:0]  second_val_i,
  output psi_pkg::cell_ctl_t                 ctl_o,
  output logic                               done_o,
  output logic signed [psi_pkg::DATA_W-1:0]  quantile_value_o,
  output logic                               set_was_empty_o,
  output logic                               values_dropped_o
);
  import psi_pkg::*;

  localparam int unsigned CntW = $clog2(MaxItems + 1);
  localparam int unsigned IdxW = Q_W + CntW;
  localparam int unsigned ProdW = DATA_W + FRAC_W;

  psi_state_e state_q, state_d;

  logic [Q_W-1:0]       qf_q;
  logic [CntW-1:0]      count_q;
  logic                 ovf_q;
  logic [CntW-1:0]      lo_q;
  logic [FRAC_W-1:0]    frac_q;
  logic                 upper_ok_q;
  logic                 empty_q;
  logic signed [DATA_W-1:0] low_q;
  logic [DATA_W-1:0]    diff_q;
  logic [ProdW-1:0]     prod_q;
  logic                 done_q;
  logic signed [DATA_W-1:0] result_q;
  logic                 empty_out_q;
  logic                 ovf_out_q;

  logic                 accept;
  logic                 full;
  logic [Q_W-1:0]       p_sat;
  logic [IdxW-1:0]      idx;
  logic [CntW-1:0]      lo_new;
  logic [DATA_W:0]      diff_wide;

  assign accept = start && !busy;
  assign full   = (count_q == CntW'(MaxItems));
  assign p_sat  = (qf_q > Q_ONE) ? Q_ONE : qf_q;
  assign idx    = IdxW'(p_sat) * IdxW'(count_q - CntW'(1));
  assign lo_new = idx[FRAC_W +: CntW];
  // Sorted order makes the upper neighbor never smaller, so the gap fits unsigned.
  assign diff_wide = {second_val_i[DATA_W-1], second_val_i}
                   - {head_val_i[DATA_W-1], head_val_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    busy        = 1'b1;
    ctl_o.ins   = 1'b0;
    ctl_o.shift = 1'b0;
    ctl_o.clr   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy      = 1'b0;
        ctl_o.ins = start && has_value_i && !full;
        if (start && last_item_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = (count_q == '0) ? ST_PROD : ST_SHIFT;
      end
      ST_SHIFT: begin
        if (lo_q != '0) begin
          ctl_o.shift = 1'b1;
        end else begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        ctl_o.clr = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qf_q    <= Q_RESET;
      count_q <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == ST_OUT);
      if (cfg_we_i) begin
        qf_q <= quantile_fraction_i;
      end
      if (state_q == ST_OUT) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (accept && has_value_i) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL: begin
        empty_q    <= (count_q == '0);
        lo_q       <= lo_new;
        frac_q     <= idx[FRAC_W-1:0];
        upper_ok_q <= (idx[FRAC_W-1:0] != '0)
                   && (({1'b0, lo_new} + (CntW+1)'(1)) < {1'b0, count_q});
        low_q      <= '0;
        diff_q     <= '0;
      end
      ST_SHIFT: begin
        if (lo_q != '0) begin
          lo_q <= lo_q - CntW'(1);
        end else begin
          low_q  <= head_val_i;
          diff_q <= upper_ok_q ? diff_wide[DATA_W-1:0] : '0;
        end
      end
      ST_PROD: begin
        prod_q <= ProdW'(diff_q) * ProdW'(frac_q);
      end
      ST_OUT: begin
        result_q    <= low_q + $signed(prod_q[ProdW-1:FRAC_W]);
        empty_out_q <= empty_q;
        ovf_out_q   <= ovf_q;
      end
      default: begin
      end
    endcase
  end

  assign done_o           = done_q;
  assign quantile_value_o = result_q;
  assign set_was_empty_o  = empty_out_q;
  assign values_dropped_o = ovf_out_q;

endmodule

// ----- rtl/core/percentile_select_interpolate.sv -----
// Collects signed Q16.16 words into a chain of sorting cells, one word per
// cycle while busy is low, and on a word marked last returns the interpolated
// quantile of the set held so far, then empties the set. A word without the
// last mark is taken and busy stays low. After a last word busy stays high
// through the multiply, shift, product and output states (no shift for an
// empty set); with lo = floor(p * (n - 1)) the lower neighbor's place, the
// chain shifts toward its head once per cycle until that neighbor reaches the
// first cell. The result is on the outputs for the single cycle that done_o is
// high, which is the first cycle with busy low again; it cannot be held off, so
// the receiver must take it then. Words beyond MaxItems are dropped and flagged.
module percentile_select_interpolate #(
  parameter int unsigned MaxItems = psi_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [psi_pkg::DATA_W-1:0]  sample_value_i,
  input  logic                               has_value_i,
  input  logic                               last_item_i,
  input  logic                               cfg_we_i,
  input  logic [psi_pkg::Q_W-1:0]            quantile_fraction_i,
  output logic                               done_o,
  output logic signed [psi_pkg::DATA_W-1:0]  quantile_value_o,
  output logic                               set_was_empty_o,
  output logic                               values_dropped_o
);
  import psi_pkg::*;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] val   [MaxItems];
  logic [MaxItems-1:0]      occ;
  logic [MaxItems-1:0]      gt;

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_val;
    logic                     prev_occ;
    logic                     prev_gt;
    logic signed [DATA_W-1:0] next_val;
    logic                     next_occ;

    if (i == 0) begin : g_head
      assign prev_val = sample_value_i;
      assign prev_occ = 1'b1;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = val[i-1];
      assign prev_occ = occ[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == MaxItems - 1) begin : g_tail
      assign next_val = val[i];
      assign next_occ = 1'b0;
    end else begin : g_inner
      assign next_val = val[i+1];
      assign next_occ = occ[i+1];
    end

    psi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .sample_i   (sample_value_i),
      .prev_val_i (prev_val),
      .prev_occ_i (prev_occ),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .next_occ_i (next_occ),
      .val_o      (val[i]),
      .occ_o      (occ[i]),
      .gt_o       (gt[i])
    );
  end

  psi_seq #(
    .MaxItems (MaxItems)
  ) u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .has_value_i         (has_value_i),
    .last_item_i         (last_item_i),
    .cfg_we_i            (cfg_we_i),
    .quantile_fraction_i (quantile_fraction_i),
    .head_val_i          (val[0]),
    .second_val_i        (val[1]),
    .ctl_o               (ctl),
    .done_o              (done_o),
    .quantile_value_o    (quantile_value_o),
    .set_was_empty_o     (set_was_empty_o),
    .values_dropped_o    (values_dropped_o)
  );

  // Occupied cells always form an unbroken run from the head of the chain.
  a_occ_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ + MaxItems'(1)) & occ) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a preceding selection");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && set_was_empty_o) |-> (quantile_value_o == '0))
    else $error("empty set gave a nonzero quantile");

  a_no_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ctl.ins)
    else $error("cell insert while selection is running");

endmodule
